// ===== rtl/core/alsse_pkg.sv =====
// Shared types and constants for the ordered list engine.
// Used by alsse_prime and array_list_sort_search_engine; depends on nothing.
`default_nettype none
package alsse_pkg;

  // Default sizes of the element store.
  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  // Fixed port widths.
  localparam int KIND_W   = 3;
  localparam int OPV_W    = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int EIDX_W   = 6;
  localparam int EVAL_W   = 32;
  localparam int LEN_W    = 7;

  // Command codes.
  localparam logic [KIND_W-1:0] K_CLEAR  = 3'd0;
  localparam logic [KIND_W-1:0] K_APPEND = 3'd1;
  localparam logic [KIND_W-1:0] K_LIST   = 3'd2;
  localparam logic [KIND_W-1:0] K_INSERT = 3'd3;
  localparam logic [KIND_W-1:0] K_DELETE = 3'd4;
  localparam logic [KIND_W-1:0] K_SORT   = 3'd5;
  localparam logic [KIND_W-1:0] K_SEARCH = 3'd6;
  localparam logic [KIND_W-1:0] K_PRIMES = 3'd7;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd3;

  // Main sequencer states.
  typedef enum logic [4:0] {
    S_IDLE, S_RESP,
    S_LRD, S_LEMIT,
    S_SRD, S_SCHK,
    S_IRD, S_IWR,
    S_DRD, S_DWR,
    S_TRDA, S_TLDA, S_TRDB, S_TCMP,
    S_PRD, S_PSTART, S_PWAIT, S_PEMIT, S_PFIN
  } eng_state_t;

  // Prime tester states.
  typedef enum logic [1:0] {
    P_IDLE, P_CHK, P_DIV, P_MOD
  } prm_state_t;

  // Verdict of the prime tester.
  typedef struct packed {
    logic done;
    logic prime;
  } prm_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/alsse_prime.sv =====
// Iterative prime tester: trial division with a bit-serial restoring divider.
// Depends on alsse_pkg for the state type and the result struct.
`default_nettype none
module alsse_prime #(
  parameter int VALUE_WIDTH = alsse_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  input  wire logic [VALUE_WIDTH-1:0] value,
  output alsse_pkg::prm_res_t         res
);
  import alsse_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  prm_state_t      state_r, state_nxt;
  prm_res_t        res_r;
  logic [W-1:0]    n_r;
  logic [W-1:0]    j_r;
  logic [W:0]      sq_r;
  logic [W-1:0]    rem_r;
  logic [W-1:0]    dvd_r;
  logic [CW-1:0]   cnt_r;
  logic [W:0]      rem_sh;
  logic            trivial_no;
  logic            sq_over;

  assign rem_sh     = {rem_r, dvd_r[W-1]};
  assign trivial_no = n_r[W-1] || (n_r <= W'(1));
  assign sq_over    = sq_r > {1'b0, n_r};
  assign res        = res_r;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      P_IDLE: begin
        if (start) state_nxt = P_CHK;
      end
      P_CHK: begin
        if (trivial_no || sq_over) state_nxt = P_IDLE;
        else state_nxt = P_DIV;
      end
      P_DIV: begin
        if (cnt_r == CW'(W - 1)) state_nxt = P_MOD;
      end
      P_MOD: begin
        if (rem_r == '0) state_nxt = P_IDLE;
        else state_nxt = P_CHK;
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  // Verdict pulse.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r <= '0;
    end else begin
      res_r.done  <= 1'b0;
      res_r.prime <= 1'b0;
      if (state_r == P_CHK && (trivial_no || sq_over)) begin
        res_r.done  <= 1'b1;
        res_r.prime <= !trivial_no;
      end else if (state_r == P_MOD && rem_r == '0) begin
        res_r.done <= 1'b1;
      end
    end
  end

  // Datapath: trial divisor, its square and one remainder bit per cycle.
  always_ff @(posedge clk) begin
    case (state_r)
      P_IDLE: begin
        n_r  <= value;
        j_r  <= W'(2);
        sq_r <= (W+1)'(4);
      end
      P_CHK: begin
        rem_r <= '0;
        dvd_r <= n_r;
        cnt_r <= '0;
      end
      P_DIV: begin
        rem_r <= (rem_sh >= {1'b0, j_r}) ? W'(rem_sh - {1'b0, j_r}) : W'(rem_sh);
        dvd_r <= {dvd_r[W-2:0], 1'b0};
        cnt_r <= cnt_r + 1'b1;
      end
      P_MOD: begin
        j_r  <= j_r + 1'b1;
        sq_r <= sq_r + {j_r, 1'b1};
      end
      default: begin
        n_r <= n_r;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/array_list_sort_search_engine.sv =====
// Ordered list engine: a signed word store with clear, append, list, insert, delete, sort, search and prime listing.
// Top level. Depends on alsse_pkg and alsse_prime.
//
// Usage: one command per input transaction (in_kind, in_operand_value,
// in_position). Every command produces one or more result transactions, the
// final one with out_last set; out_length carries the count after the command.
// Commands run one at a time: in_stall is high from acceptance until the last
// result has been loaded into the output register.
// Insert, delete, search and list walk the entries they touch through the
// single read port of the store. Sort does one read per compare. List-primes
// runs trial division per element with the bit-serial divider of alsse_prime.
// Reset empties the list; store contents are undefined until written.
// The output register holds a result while out_stall is high, and the
// sequencer waits for a free output slot before producing the next one.
`default_nettype none
module array_list_sort_search_engine #(
  parameter int DEPTH       = alsse_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = alsse_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [alsse_pkg::KIND_W-1:0]      in_kind,
  input  wire logic signed [alsse_pkg::OPV_W-1:0] in_operand_value,
  input  wire logic [alsse_pkg::POS_W-1:0]       in_position,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [alsse_pkg::STATUS_W-1:0]         out_status,
  output logic [alsse_pkg::EIDX_W-1:0]           out_elem_index,
  output logic signed [alsse_pkg::EVAL_W-1:0]    out_elem_value,
  output logic                                   out_found,
  output logic                                   out_last,
  output logic [alsse_pkg::LEN_W-1:0]            out_length
);
  import alsse_pkg::*;

  localparam int W  = VALUE_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Element store: one write port, one registered read port.
  logic [W-1:0]  mem_r [DEPTH];
  logic [W-1:0]  rd_data_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [W-1:0]  wr_data;
  logic          wr_en;

  eng_state_t state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [CW-1:0]       jdx_r, jdx_nxt;
  logic [W-1:0]        opv_r, opv_nxt;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [W-1:0]        a_r, a_nxt;
  logic [STATUS_W-1:0] rsp_status_r, rsp_status_nxt;
  logic [AW-1:0]       rsp_idx_r, rsp_idx_nxt;
  logic [W-1:0]        rsp_val_r, rsp_val_nxt;
  logic                rsp_found_r, rsp_found_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  logic [AW-1:0]       pend_idx_r, pend_idx_nxt;
  logic [W-1:0]        pend_val_r, pend_val_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [AW-1:0]       out_idx_r, out_idx_nxt;
  logic [W-1:0]        out_val_r, out_val_nxt;
  logic                out_found_r, out_found_nxt;
  logic                out_last_r, out_last_nxt;
  logic [LEN_W-1:0]    out_len_r, out_len_nxt;

  logic          slot_free;
  logic          in_acc;
  logic [63:0]   opv_ext;
  logic          full;
  logic          prm_start;
  prm_res_t      prm_res;
  logic [63:0]   out_val64;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign opv_ext   = {{32{in_operand_value[OPV_W-1]}}, in_operand_value};
  assign full      = (count_r == CW'(DEPTH));
  assign prm_start = (state_r == S_PSTART);

  // The tester samples the entry straight from the read port when started.
  alsse_prime #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_prime (
    .clk   (clk),
    .rst_n (rst_n),
    .start (prm_start),
    .value (rd_data_r),
    .res   (prm_res)
  );

  // Store write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    jdx_r        <= jdx_nxt;
    opv_r        <= opv_nxt;
    pos_r        <= pos_nxt;
    a_r          <= a_nxt;
    rsp_status_r <= rsp_status_nxt;
    rsp_idx_r    <= rsp_idx_nxt;
    rsp_val_r    <= rsp_val_nxt;
    rsp_found_r  <= rsp_found_nxt;
    pend_idx_r   <= pend_idx_nxt;
    pend_val_r   <= pend_val_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_val_r    <= out_val_nxt;
    out_found_r  <= out_found_nxt;
    out_last_r   <= out_last_nxt;
    out_len_r    <= out_len_nxt;
  end

  // Sequencer: next state, store accesses and result loading.
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    jdx_nxt        = jdx_r;
    opv_nxt        = opv_r;
    pos_nxt        = pos_r;
    a_nxt          = a_r;
    rsp_status_nxt = rsp_status_r;
    rsp_idx_nxt    = rsp_idx_r;
    rsp_val_nxt    = rsp_val_r;
    rsp_found_nxt  = rsp_found_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    pend_val_nxt   = pend_val_r;
    out_valid_nxt  = slot_free ? 1'b0 : out_valid_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_val_nxt    = out_val_r;
    out_found_nxt  = out_found_r;
    out_last_nxt   = out_last_r;
    out_len_nxt    = out_len_r;
    rd_addr        = idx_r[AW-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx_r[AW-1:0];
    wr_data        = rd_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          opv_nxt        = opv_ext[W-1:0];
          pos_nxt        = in_position;
          rsp_status_nxt = ST_OK;
          rsp_idx_nxt    = '0;
          rsp_val_nxt    = '0;
          rsp_found_nxt  = 1'b0;
          idx_nxt        = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_RESP;
          case (in_kind)
            K_CLEAR: begin
              count_nxt = '0;
            end
            K_APPEND: begin
              if (full) begin
                rsp_status_nxt = ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = count_r[AW-1:0];
                wr_data   = opv_ext[W-1:0];
                count_nxt = count_r + 1'b1;
              end
            end
            K_LIST: begin
              if (count_r == '0) rsp_status_nxt = ST_NONE;
              else state_nxt = S_LRD;
            end
            K_INSERT: begin
              if ({1'b0, in_position} > 8'(count_r)) begin
                rsp_status_nxt = ST_BAD_POS;
              end else if (full) begin
                rsp_status_nxt = ST_FULL;
              end else begin
                idx_nxt   = count_r;
                state_nxt = S_IRD;
              end
            end
            K_DELETE: begin
              if ({1'b0, in_position} >= 8'(count_r)) begin
                rsp_status_nxt = ST_BAD_POS;
              end else begin
                idx_nxt   = CW'(in_position);
                state_nxt = S_DRD;
              end
            end
            K_SORT: begin
              state_nxt = S_TRDA;
            end
            K_SEARCH: begin
              state_nxt = S_SRD;
            end
            K_PRIMES: begin
              state_nxt = S_PRD;
            end
            default: begin
              state_nxt = S_RESP;
            end
          endcase
        end
      end

      // Single final result from the response registers.
      S_RESP: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rsp_status_r;
          out_idx_nxt    = rsp_idx_r;
          out_val_nxt    = rsp_val_r;
          out_found_nxt  = rsp_found_r;
          out_last_nxt   = 1'b1;
          out_len_nxt    = LEN_W'(count_r);
          state_nxt      = S_IDLE;
        end
      end

      // Listing: read one entry, then emit it.
      S_LRD: begin
        state_nxt = S_LEMIT;
      end
      S_LEMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_idx_nxt    = idx_r[AW-1:0];
          out_val_nxt    = rd_data_r;
          out_found_nxt  = 1'b0;
          out_last_nxt   = ({1'b0, idx_r} + 1'b1) == {1'b0, count_r};
          out_len_nxt    = LEN_W'(count_r);
          idx_nxt        = idx_r + 1'b1;
          state_nxt      = out_last_nxt ? S_IDLE : S_LRD;
        end
      end

      // Search: stop at the first match.
      S_SRD: begin
        if (idx_r == count_r) begin
          rsp_status_nxt = ST_NONE;
          state_nxt      = S_RESP;
        end else begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (rd_data_r == opv_r) begin
          rsp_idx_nxt   = idx_r[AW-1:0];
          rsp_val_nxt   = rd_data_r;
          rsp_found_nxt = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SRD;
        end
      end

      // Insert: move the tail up one entry at a time, top first.
      S_IRD: begin
        if (idx_r == CW'(pos_r)) begin
          wr_en     = 1'b1;
          wr_data   = opv_r;
          count_nxt = count_r + 1'b1;
          state_nxt = S_RESP;
        end else begin
          rd_addr   = AW'(idx_r - 1'b1);
          state_nxt = S_IWR;
        end
      end
      S_IWR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r - 1'b1;
        state_nxt = S_IRD;
      end

      // Delete: move the tail down one entry at a time, bottom first.
      S_DRD: begin
        if (({1'b0, idx_r} + 1'b1) >= {1'b0, count_r}) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_RESP;
        end else begin
          rd_addr   = AW'(idx_r + 1'b1);
          state_nxt = S_DWR;
        end
      end
      S_DWR: begin
        wr_en     = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        state_nxt = S_DRD;
      end

      // Exchange sort: entry i is held in a_r over its inner pass.
      S_TRDA: begin
        if (({1'b0, idx_r} + 1'b1) >= {1'b0, count_r}) begin
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_TLDA;
        end
      end
      S_TLDA: begin
        a_nxt     = rd_data_r;
        jdx_nxt   = idx_r + 1'b1;
        state_nxt = S_TRDB;
      end
      S_TRDB: begin
        rd_addr = jdx_r[AW-1:0];
        if (jdx_r == count_r) begin
          wr_en     = 1'b1;
          wr_data   = a_r;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_TRDA;
        end else begin
          state_nxt = S_TCMP;
        end
      end
      S_TCMP: begin
        if ($signed(a_r) < $signed(rd_data_r)) begin
          wr_en   = 1'b1;
          wr_addr = jdx_r[AW-1:0];
          wr_data = a_r;
          a_nxt   = rd_data_r;
        end
        jdx_nxt   = jdx_r + 1'b1;
        state_nxt = S_TRDB;
      end

      // Prime listing: one prime is held back so the last one can be marked.
      S_PRD: begin
        if (idx_r == count_r) state_nxt = S_PFIN;
        else state_nxt = S_PSTART;
      end
      S_PSTART: begin
        a_nxt     = rd_data_r;
        state_nxt = S_PWAIT;
      end
      S_PWAIT: begin
        if (prm_res.done) begin
          if (!prm_res.prime) begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_PRD;
          end else if (pend_valid_r) begin
            state_nxt = S_PEMIT;
          end else begin
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = idx_r[AW-1:0];
            pend_val_nxt   = a_r;
            idx_nxt        = idx_r + 1'b1;
            state_nxt      = S_PRD;
          end
        end
      end
      S_PEMIT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_idx_nxt    = pend_idx_r;
          out_val_nxt    = pend_val_r;
          out_found_nxt  = 1'b0;
          out_last_nxt   = 1'b0;
          out_len_nxt    = LEN_W'(count_r);
          pend_idx_nxt   = idx_r[AW-1:0];
          pend_val_nxt   = a_r;
          idx_nxt        = idx_r + 1'b1;
          state_nxt      = S_PRD;
        end
      end
      S_PFIN: begin
        if (pend_valid_r) begin
          rsp_idx_nxt = pend_idx_r;
          rsp_val_nxt = pend_val_r;
        end else begin
          rsp_status_nxt = ST_NONE;
        end
        state_nxt = S_RESP;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result ports.
  assign out_val64      = 64'(out_val_r);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_elem_index = EIDX_W'(out_idx_r);
  assign out_elem_value = out_val64[EVAL_W-1:0];
  assign out_found      = out_found_r;
  assign out_last       = out_last_r;
  assign out_length     = out_len_r;

  // The count never exceeds the store depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  // An accepted command always leaves the idle state.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("command accepted but sequencer stayed idle");

  // The prime tester reports only while the sequencer waits for it.
  a_prime_sync: assert property (@(posedge clk) disable iff (!rst_n)
    prm_res.done |-> state_r == S_PWAIT)
    else $error("prime verdict outside the wait state");

  // The store is written only while a command is in progress or being accepted.
  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r != S_IDLE || in_acc))
    else $error("store written while idle");

endmodule
`default_nettype wire

// ===== bench/array_list_sort_search_engine_tb.sv =====
// Self-checking testbench for the ordered list engine (array_list_sort_search_engine).
// Drives command transactions with random gaps, predicts every result and checks
// it field by field. Depends on alsse_pkg and the engine RTL.
`timescale 1ns / 100ps
`default_nettype none
module array_list_sort_search_engine_tb;
  import alsse_pkg::*;

  localparam int LIST_MAX = 64;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [OPV_W-1:0]  opv;
    logic [POS_W-1:0]         pos;
    bit                       drain;
  } command_t;

  typedef struct {
    logic [STATUS_W-1:0]      status;
    logic [EIDX_W-1:0]        idx;
    logic signed [EVAL_W-1:0] val;
    logic                     found;
    logic                     last;
    logic [LEN_W-1:0]         len;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KIND_W-1:0] in_kind = '0;
  logic signed [OPV_W-1:0] in_operand_value = '0;
  logic [POS_W-1:0] in_position = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [STATUS_W-1:0] out_status;
  logic [EIDX_W-1:0] out_elem_index;
  logic signed [EVAL_W-1:0] out_elem_value;
  logic out_found;
  logic out_last;
  logic [LEN_W-1:0] out_length;

  array_list_sort_search_engine u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_kind(in_kind), .in_operand_value(in_operand_value), .in_position(in_position),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_elem_index(out_elem_index),
    .out_elem_value(out_elem_value), .out_found(out_found),
    .out_last(out_last), .out_length(out_length)
  );

  // Pending commands, expected results and the shadow copy of the list.
  command_t cmd_q[$];
  result_t  result_q[$];
  logic signed [OPV_W-1:0] shadow_list[LIST_MAX];
  int shadow_count = 0;
  logic signed [OPV_W-1:0] value_history[$];
  int sent = 0;
  int errors = 0;
  bit long_hold = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stretches with no idling on either side.
  function automatic bit calm();
    return ((sent / 50) % 4) == 3;
  endfunction

  function automatic bit is_prime(logic signed [OPV_W-1:0] v);
    longint n;
    n = v;
    if (n <= 1) return 1'b0;
    for (longint j = 2; j * j <= n; j++)
      if (n % j == 0) return 1'b0;
    return 1'b1;
  endfunction

  function automatic void expect_result(logic [STATUS_W-1:0] st, int idx,
                                        logic signed [EVAL_W-1:0] val, logic fnd, logic lst);
    result_t r;
    r.status = st;
    r.idx = idx[EIDX_W-1:0];
    r.val = val;
    r.found = fnd;
    r.last = lst;
    r.len = shadow_count[LEN_W-1:0];
    result_q.push_back(r);
  endfunction

  // Update the shadow list for one command and queue the results it causes.
  function automatic void apply_command(command_t c);
    int hits;
    logic signed [OPV_W-1:0] t;
    hits = 0;
    case (c.kind)
      K_CLEAR: begin
        shadow_count = 0;
        expect_result(ST_OK, 0, 0, 0, 1);
      end
      K_APPEND: begin
        if (shadow_count >= LIST_MAX) begin
          expect_result(ST_FULL, 0, 0, 0, 1);
        end else begin
          shadow_list[shadow_count] = c.opv;
          shadow_count++;
          expect_result(ST_OK, 0, 0, 0, 1);
        end
      end
      K_LIST: begin
        if (shadow_count == 0) expect_result(ST_NONE, 0, 0, 0, 1);
        for (int i = 0; i < shadow_count; i++)
          expect_result(ST_OK, i, shadow_list[i], 0, i + 1 == shadow_count);
      end
      K_INSERT: begin
        if (c.pos > shadow_count) begin
          expect_result(ST_BAD_POS, 0, 0, 0, 1);
        end else if (shadow_count >= LIST_MAX) begin
          expect_result(ST_FULL, 0, 0, 0, 1);
        end else begin
          for (int i = shadow_count; i > c.pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[c.pos] = c.opv;
          shadow_count++;
          expect_result(ST_OK, 0, 0, 0, 1);
        end
      end
      K_DELETE: begin
        if (c.pos >= shadow_count) begin
          expect_result(ST_BAD_POS, 0, 0, 0, 1);
        end else begin
          for (int i = c.pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i+1];
          shadow_count--;
          expect_result(ST_OK, 0, 0, 0, 1);
        end
      end
      K_SORT: begin
        for (int i = 0; i + 1 < shadow_count; i++)
          for (int j = i + 1; j < shadow_count; j++)
            if (shadow_list[i] < shadow_list[j]) begin
              t = shadow_list[i];
              shadow_list[i] = shadow_list[j];
              shadow_list[j] = t;
            end
        expect_result(ST_OK, 0, 0, 0, 1);
      end
      K_SEARCH: begin
        for (int i = 0; i < shadow_count; i++)
          if (hits == 0 && shadow_list[i] == c.opv) begin
            expect_result(ST_OK, i, shadow_list[i], 1, 1);
            hits = 1;
          end
        if (hits == 0) expect_result(ST_NONE, 0, 0, 0, 1);
      end
      default: begin
        for (int i = 0; i < shadow_count; i++)
          if (is_prime(shadow_list[i])) begin
            expect_result(ST_OK, i, shadow_list[i], 0, 0);
            hits++;
          end
        if (hits == 0) expect_result(ST_NONE, 0, 0, 0, 1);
        else result_q[result_q.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  // Driver: offers one queued command at a time, with a random gap after each.
  int gap_left = 0;
  always @(posedge clk) begin
    logic vld;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      vld = in_valid;
      if (in_valid && !in_stall) begin
        apply_command(cmd_q.pop_front());
        sent++;
        gap_left = calm() ? 0 : $urandom_range(0, 9);
        vld = 1'b0;
      end
      if (!vld) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_q.size() > 0) begin
          if (cmd_q[0].drain) begin
            // Hold off until every outstanding result has been seen.
            if (result_q.size() == 0) void'(cmd_q.pop_front());
          end else begin
            in_kind <= cmd_q[0].kind;
            in_operand_value <= cmd_q[0].opv;
            in_position <= cmd_q[0].pos;
            vld = 1'b1;
          end
        end
      end
      in_valid <= vld;
    end
  end

  // One long receiver hold while the sender keeps offering commands.
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!hold_done && sent >= 60) begin
      hold_cycles++;
      if (hold_cycles >= 400) begin
        long_hold <= 1'b0;
        hold_done <= 1'b1;
      end else begin
        long_hold <= 1'b1;
      end
    end
  end

  // Monitor: checks each result transaction against the oldest expectation.
  int stall_left = 0;
  always @(posedge clk) begin
    result_t e;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: status %0d idx %0d value %0d",
                                     out_status, out_elem_index, out_elem_value);
        end else begin
          e = result_q.pop_front();
          if (out_status !== e.status || out_elem_index !== e.idx ||
              out_elem_value !== e.val || out_found !== e.found ||
              out_last !== e.last || out_length !== e.len) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp st %0d idx %0d val %0d fnd %0d last %0d len %0d / %s",
                       e.status, e.idx, e.val, e.found, e.last, e.len,
                       $sformatf("got st %0d idx %0d val %0d fnd %0d last %0d len %0d",
                                 out_status, out_elem_index, out_elem_value, out_found,
                                 out_last, out_length));
          end
        end
        stall_left = calm() ? 0 : $urandom_range(0, 9);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= long_hold || (stall_left > 0);
    end
  end

  task automatic push(logic [KIND_W-1:0] k, logic signed [OPV_W-1:0] v, int p);
    command_t c;
    c.kind = k;
    c.opv = v;
    c.pos = p[POS_W-1:0];
    c.drain = 1'b0;
    cmd_q.push_back(c);
    if (k == K_APPEND || k == K_INSERT) value_history.push_back(v);
  endtask

  task automatic push_drain();
    command_t c;
    c.kind = K_CLEAR;
    c.opv = '0;
    c.pos = '0;
    c.drain = 1'b1;
    cmd_q.push_back(c);
  endtask

  // Stored values stay cheap for the trial divider: small, negative or large and even.
  function automatic logic signed [OPV_W-1:0] store_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 3))
      0, 1: return $urandom_range(0, 127);
      2: return r | 32'h8000_0000;
      default: return r & 32'h7FFF_FFFE;
    endcase
  endfunction

  function automatic logic signed [OPV_W-1:0] search_value();
    if (value_history.size() > 0 && $urandom_range(0, 1))
      return value_history[$urandom_range(0, value_history.size() - 1)];
    return $urandom;
  endfunction

  function automatic int rand_pos();
    return $urandom_range(0, 3) == 0 ? $urandom_range(0, 127) : $urandom_range(0, 20);
  endfunction

  // Stimulus: directed corner cases, a fill to capacity, then random commands.
  initial begin
    int w;
    push(K_APPEND, 0, 0);
    push(K_APPEND, -1, 0);
    push(K_APPEND, 32'sh8000_0000, 0);
    push(K_APPEND, 2, 0);
    push(K_APPEND, 1, 0);
    push(K_APPEND, 97, 0);
    push(K_APPEND, 32'sh7FFF_FFFE, 0);
    push(K_LIST, 0, 0);
    push(K_SEARCH, 2, 0);
    push(K_SEARCH, 32'sh7FFF_FFFF, 0);
    push(K_PRIMES, 0, 0);
    push(K_INSERT, 5, 0);
    push(K_INSERT, 3, 8);
    push(K_INSERT, 9, 127);
    push(K_DELETE, 0, 9);
    push(K_DELETE, 0, 0);
    push(K_SORT, 0, 0);
    push(K_LIST, 0, 0);
    push(K_CLEAR, 0, 0);
    push(K_LIST, 0, 0);
    push(K_PRIMES, 0, 0);
    push(K_DELETE, 0, 0);
    push(K_SORT, 0, 0);
    push(K_SEARCH, 0, 0);
    push(K_APPEND, 4, 0);
    push(K_PRIMES, 0, 0);
    push_drain();
    // Fill to capacity and exercise the full store.
    push(K_CLEAR, 0, 0);
    for (int i = 0; i < 66; i++) push(K_APPEND, store_value(), 0);
    push(K_INSERT, 7, 10);
    push(K_INSERT, 7, 65);
    push(K_SORT, 0, 0);
    push(K_LIST, 0, 0);
    push(K_PRIMES, 0, 0);
    push(K_SEARCH, search_value(), 0);
    push(K_DELETE, 0, 63);
    push(K_INSERT, 11, 63);
    push(K_CLEAR, 0, 0);
    for (int i = 0; i < 180; i++) begin
      w = $urandom_range(0, 99);
      if (w < 35) push(K_APPEND, store_value(), 0);
      else if (w < 50) push(K_INSERT, store_value(), rand_pos());
      else if (w < 60) push(K_DELETE, 0, rand_pos());
      else if (w < 68) push(K_LIST, 0, 0);
      else if (w < 75) push(K_SORT, 0, 0);
      else if (w < 87) push(K_SEARCH, search_value(), 0);
      else if (w < 95) push(K_PRIMES, 0, 0);
      else push(K_CLEAR, 0, 0);
      if (i == 120) push_drain();
    end
    wait (rst_n && cmd_q.size() == 0 && !in_valid && result_q.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0 && result_q.size() == 0) begin
      $display("array_list_sort_search_engine regression: pass");
    end else begin
      $display("array_list_sort_search_engine regression: fail");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #60_000_000;
    $display("array_list_sort_search_engine regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
